// ===== rtl/roller_shutter_travel_controller_top_assert.svh =====
// assertion macros for the roller shutter travel controller top level
// used by roller_shutter_travel_controller_top.sv, no other dependencies
`ifndef ROLLER_SHUTTER_TRAVEL_CONTROLLER_TOP_ASSERT_SVH
`define ROLLER_SHUTTER_TRAVEL_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication
`define RSTC_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication
`define RSTC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ===== rtl/rstc_pkg.sv =====
// shared types and constants of the roller shutter travel controller
// no dependencies
`default_nettype none

package rstc_pkg;

   typedef enum logic [1:0] {
      ACT_COMMAND = 2'd0,
      ACT_TARGET  = 2'd1,
      ACT_APPLY   = 2'd2,
      ACT_ELAPSED = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MOTION_UP   = 2'd0,
      MOTION_DOWN = 2'd1,
      MOTION_STOP = 2'd2
   } motion_type;

   typedef enum logic [1:0] {
      CSR_UP_SECS     = 2'd0,
      CSR_DOWN_SECS   = 2'd1,
      CSR_ACTIVE_LVL  = 2'd2,
      CSR_IDLE_LVL    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCALE,
      ST_DIV,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic stage1;
      logic stage2;
      logic div_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_elapsed;
      logic div_last;
   } dp_status_type;

   localparam int MS_WIDTH       = 22;
   localparam int DIVIDEND_WIDTH = MS_WIDTH + 1;
   localparam int DIV_STEPS      = DIVIDEND_WIDTH;
   localparam int COUNT_WIDTH    = $clog2(DIV_STEPS);
   localparam int DIVISOR_WIDTH  = 12;
   localparam int RUN_WIDTH      = 18;
   localparam int POS_WIDTH      = 7;

   localparam logic [7:0]  UP_SECS_RESET   = 8'd60;
   localparam logic [7:0]  DOWN_SECS_RESET = 8'd60;
   localparam logic        ACTIVE_RESET    = 1'b1;
   localparam logic        IDLE_RESET      = 1'b0;
   localparam logic [6:0]  POS_MAX         = 7'd100;
   localparam logic [9:0]  MS_PER_SEC      = 10'd1000;

endpackage

`default_nettype wire

// ===== rtl/rstc_ctrl.sv =====
// sequencer of the roller shutter travel controller
// depends on rstc_pkg; drives the datapath commands and the handshakes
`default_nettype none

module rstc_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   input  rstc_pkg::dp_status_type status,
   output rstc_pkg::dp_cmd_type   cmd
);

   rstc_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rstc_pkg::ST_IDLE: begin
            if (req_valid) state_in = rstc_pkg::ST_LOAD;
         end
         rstc_pkg::ST_LOAD: begin
            state_in = rstc_pkg::ST_SCALE;
         end
         rstc_pkg::ST_SCALE: begin
            state_in = status.is_elapsed ? rstc_pkg::ST_DIV : rstc_pkg::ST_DONE;
         end
         rstc_pkg::ST_DIV: begin
            if (status.div_last) state_in = rstc_pkg::ST_DONE;
         end
         rstc_pkg::ST_DONE: begin
            if (out_free) state_in = rstc_pkg::ST_IDLE;
         end
         default: begin
            state_in = rstc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         rstc_pkg::ST_IDLE:  cmd.capture  = req_valid;
         rstc_pkg::ST_LOAD:  cmd.stage1   = 1'b1;
         rstc_pkg::ST_SCALE: cmd.stage2   = 1'b1;
         rstc_pkg::ST_DIV:   cmd.div_step = 1'b1;
         rstc_pkg::ST_DONE:  cmd.commit   = out_free;
         default:            cmd = '0;
      endcase
   end

   // result register stays full until the far side takes the transfer
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rstc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != rstc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/rstc_dp.sv =====
// datapath of the roller shutter travel controller: settings, shutter state,
// run time multiplier, serial divider and result registers; depends on rstc_pkg
`default_nettype none

module rstc_dp (
   input  wire                    clock,
   input  wire                    reset,
   input  rstc_pkg::dp_cmd_type   cmd,
   output rstc_pkg::dp_status_type status,
   input  wire                    csr_write,
   input  wire  [1:0]             csr_index,
   input  wire  [7:0]             csr_data,
   input  wire  [1:0]             req_action,
   input  wire  [1:0]             req_order,
   input  wire  [6:0]             req_target_position,
   input  wire                    req_moved_down,
   input  wire  [21:0]            req_elapsed_ms,
   output logic [17:0]            rsp_run_time_ms,
   output logic [1:0]             rsp_motion_state,
   output logic                   rsp_up_relay_level,
   output logic                   rsp_down_relay_level,
   output logic [6:0]             rsp_position_percent
);

   localparam int DW = rstc_pkg::DIVIDEND_WIDTH;
   localparam int VW = rstc_pkg::DIVISOR_WIDTH;
   localparam int CW = rstc_pkg::COUNT_WIDTH;
   localparam int RW = rstc_pkg::RUN_WIDTH;

   // settings
   logic [7:0] up_secs_ff, down_secs_ff;
   logic       active_lvl_ff, idle_lvl_ff;

   // shutter state
   rstc_pkg::motion_type pending_ff, current_ff, pending_in, current_in;
   logic [6:0] position_ff, position_in;
   logic       up_pin_ff, down_pin_ff, up_pin_in, down_pin_in;

   // captured item
   logic [1:0]  action_ff, order_ff;
   logic [6:0]  target_ff;
   logic        down_ff;
   logic [21:0] ms_ff;

   // arithmetic
   logic [RW-1:0] mul_ff, run_ff, run_in;
   logic          dir_down_ff;
   logic [VW-1:0] divisor_ff;
   logic [VW-1:0] rem_ff;
   logic [DW-1:0] quot_ff;
   logic [CW-1:0] count_ff;

   // result registers
   logic [RW-1:0] out_run_ff;
   logic [1:0]    out_motion_ff;
   logic          out_up_ff, out_down_ff;
   logic [6:0]    out_pos_ff;

   // stage 1 terms
   logic [6:0]    target_sat, distance;
   logic          goes_down;
   logic [7:0]    mul_secs, div_secs;
   logic [9:0]    mul_b;
   logic [RW-1:0] product;
   logic [VW-1:0] divisor_calc;

   always_comb begin
      target_sat = (target_ff > rstc_pkg::POS_MAX) ? rstc_pkg::POS_MAX : target_ff;
      goes_down  = target_sat > position_ff;
      distance   = goes_down ? (target_sat - position_ff) : (position_ff - target_sat);
      if (action_ff == rstc_pkg::ACT_COMMAND) begin
         mul_secs = (order_ff == rstc_pkg::MOTION_DOWN) ? down_secs_ff : up_secs_ff;
         mul_b    = rstc_pkg::MS_PER_SEC;
      end else begin
         mul_secs = goes_down ? down_secs_ff : up_secs_ff;
         mul_b    = {3'b000, distance};
      end
      product  = {10'd0, mul_secs} * {8'd0, mul_b};
      div_secs = down_ff ? down_secs_ff : up_secs_ff;
      // zero seconds would divide by zero, one second is used instead
      if (div_secs == 8'd0) div_secs = 8'd1;
      divisor_calc = ({4'd0, div_secs} << 3) + ({4'd0, div_secs} << 1);
   end

   // stage 2 terms
   logic [RW-1:0] scaled;
   logic [DW-1:0] dividend;

   assign scaled   = (mul_ff << 3) + (mul_ff << 1);
   assign dividend = down_ff ? {1'b0, ms_ff}
                             : ({1'b0, ms_ff} + {{(DW-VW){1'b0}}, divisor_ff} - DW'(1));

   // one quotient bit per cycle
   logic [VW:0]   trial;
   logic          q_bit;
   logic [VW-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quot_ff[DW-1]};
      q_bit  = trial >= {1'b0, divisor_ff};
      rem_in = q_bit ? VW'(trial - {1'b0, divisor_ff}) : trial[VW-1:0];
   end

   // state update at the end of the item
   logic [6:0] room;

   always_comb begin
      pending_in  = pending_ff;
      current_in  = current_ff;
      position_in = position_ff;
      up_pin_in   = up_pin_ff;
      down_pin_in = down_pin_ff;
      run_in      = '0;
      room        = rstc_pkg::POS_MAX - position_ff;
      case (action_ff)
         rstc_pkg::ACT_COMMAND: begin
            // any command while moving turns into a stop
            if (current_ff != rstc_pkg::MOTION_STOP) begin
               pending_in = rstc_pkg::MOTION_STOP;
            end else if (order_ff == rstc_pkg::MOTION_UP) begin
               pending_in = rstc_pkg::MOTION_UP;
               run_in     = run_ff;
            end else if (order_ff == rstc_pkg::MOTION_DOWN) begin
               pending_in = rstc_pkg::MOTION_DOWN;
               run_in     = run_ff;
            end else begin
               pending_in = rstc_pkg::MOTION_STOP;
            end
         end
         rstc_pkg::ACT_TARGET: begin
            pending_in = dir_down_ff ? rstc_pkg::MOTION_DOWN : rstc_pkg::MOTION_UP;
            run_in     = run_ff;
         end
         rstc_pkg::ACT_APPLY: begin
            current_in = pending_ff;
            case (pending_ff)
               rstc_pkg::MOTION_UP: begin
                  up_pin_in   = active_lvl_ff;
                  down_pin_in = idle_lvl_ff;
               end
               rstc_pkg::MOTION_DOWN: begin
                  up_pin_in   = idle_lvl_ff;
                  down_pin_in = active_lvl_ff;
               end
               default: begin
                  up_pin_in   = idle_lvl_ff;
                  down_pin_in = idle_lvl_ff;
               end
            endcase
         end
         rstc_pkg::ACT_ELAPSED: begin
            if (down_ff) begin
               position_in = (quot_ff >= {{(DW-7){1'b0}}, room})
                           ? rstc_pkg::POS_MAX : position_ff + quot_ff[6:0];
            end else begin
               position_in = (quot_ff >= {{(DW-7){1'b0}}, position_ff})
                           ? 7'd0 : position_ff - quot_ff[6:0];
            end
         end
         default: begin
            run_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_secs_ff    <= rstc_pkg::UP_SECS_RESET;
         down_secs_ff  <= rstc_pkg::DOWN_SECS_RESET;
         active_lvl_ff <= rstc_pkg::ACTIVE_RESET;
         idle_lvl_ff   <= rstc_pkg::IDLE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rstc_pkg::CSR_UP_SECS:    up_secs_ff    <= csr_data;
            rstc_pkg::CSR_DOWN_SECS:  down_secs_ff  <= csr_data;
            rstc_pkg::CSR_ACTIVE_LVL: active_lvl_ff <= csr_data[0];
            rstc_pkg::CSR_IDLE_LVL:   idle_lvl_ff   <= csr_data[0];
            default:                  up_secs_ff    <= up_secs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= rstc_pkg::MOTION_STOP;
         current_ff  <= rstc_pkg::MOTION_STOP;
         position_ff <= 7'd0;
         up_pin_ff   <= rstc_pkg::IDLE_RESET;
         down_pin_ff <= rstc_pkg::IDLE_RESET;
      end else if (cmd.commit) begin
         pending_ff  <= pending_in;
         current_ff  <= current_in;
         position_ff <= position_in;
         up_pin_ff   <= up_pin_in;
         down_pin_ff <= down_pin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         order_ff  <= req_order;
         target_ff <= req_target_position;
         down_ff   <= req_moved_down;
         ms_ff     <= req_elapsed_ms;
      end
      if (cmd.stage1) begin
         mul_ff      <= product;
         dir_down_ff <= goes_down;
         divisor_ff  <= divisor_calc;
      end
      if (cmd.stage2) begin
         run_ff   <= (action_ff == rstc_pkg::ACT_TARGET) ? scaled : mul_ff;
         quot_ff  <= dividend;
         rem_ff   <= '0;
         count_ff <= '0;
      end
      if (cmd.div_step) begin
         quot_ff  <= {quot_ff[DW-2:0], q_bit};
         rem_ff   <= rem_in;
         count_ff <= count_ff + CW'(1);
      end
      if (cmd.commit) begin
         out_run_ff    <= run_in;
         out_motion_ff <= current_in;
         out_up_ff     <= up_pin_in;
         out_down_ff   <= down_pin_in;
         out_pos_ff    <= position_in;
      end
   end

   assign status.is_elapsed = (action_ff == rstc_pkg::ACT_ELAPSED);
   assign status.div_last   = (count_ff == CW'(rstc_pkg::DIV_STEPS - 1));

   assign rsp_run_time_ms      = out_run_ff;
   assign rsp_motion_state     = out_motion_ff;
   assign rsp_up_relay_level   = out_up_ff;
   assign rsp_down_relay_level = out_down_ff;
   assign rsp_position_percent = out_pos_ff;

endmodule

`default_nettype wire

// ===== rtl/roller_shutter_travel_controller_top.sv =====
// Roller shutter travel controller, two relays. One result per input transfer.
// Command, target and apply items go through the load, scale and done states;
// an elapsed report also goes through the 23-step serial divider that
// turns milliseconds into percent. A new item is taken as soon as the
// previous one has moved into the result register, even if that result is
// still stalled. Settings written over the csr port take effect on the next
// item; relay pins change only on an apply item. csr_ready is always high.
// depends on rstc_pkg, rstc_ctrl, rstc_dp and the assertion macro header
`default_nettype none

`include "roller_shutter_travel_controller_top_assert.svh"

module roller_shutter_travel_controller_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_action,
   input  wire  [1:0]  req_order,
   input  wire  [6:0]  req_target_position,
   input  wire         req_moved_down,
   input  wire  [21:0] req_elapsed_ms,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [17:0] rsp_run_time_ms,
   output logic [1:0]  rsp_motion_state,
   output logic        rsp_up_relay_level,
   output logic        rsp_down_relay_level,
   output logic [6:0]  rsp_position_percent,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [7:0]  csr_data
);

   rstc_pkg::dp_cmd_type    cmd;
   rstc_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   rstc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rstc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write            (csr_valid & csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_action           (req_action),
      .req_order            (req_order),
      .req_target_position  (req_target_position),
      .req_moved_down       (req_moved_down),
      .req_elapsed_ms       (req_elapsed_ms),
      .rsp_run_time_ms      (rsp_run_time_ms),
      .rsp_motion_state     (rsp_motion_state),
      .rsp_up_relay_level   (rsp_up_relay_level),
      .rsp_down_relay_level (rsp_down_relay_level),
      .rsp_position_percent (rsp_position_percent)
   );

   // an accepted transfer makes the input side busy in the next cycle
   `RSTC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // tracked position never leaves the clamp range
   `RSTC_ASSERT_IMPL(a_position_range, clock, reset, rsp_valid, rsp_position_percent <= 7'd100)
   // a result only appears while an item was being worked on
   `RSTC_ASSERT_IMPL(a_result_from_item, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

`default_nettype wire
